FILE: design/bsfp_pkg.sv
// ----------------------------------------------------------------------------
// bsfp_pkg
// Shared codes and controller/datapath interface types for the buffered
// serial FIFO pair.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfp_pkg;

    // operation codes
    localparam logic [2:0] OP_LINE_RX   = 3'd0;
    localparam logic [2:0] OP_CPU_READ  = 3'd1;
    localparam logic [2:0] OP_CPU_WRITE = 3'd2;
    localparam logic [2:0] OP_TX_READY  = 3'd3;
    localparam logic [2:0] OP_FLUSH_RX  = 3'd4;
    localparam logic [2:0] OP_FLUSH_TX  = 3'd5;

    // result codes
    localparam logic [1:0] RC_OK       = 2'd0;
    localparam logic [1:0] RC_EMPTY    = 2'd1;
    localparam logic [1:0] RC_FULL     = 2'd2;
    localparam logic [1:0] RC_LINE_ERR = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic       take;
        logic       rx_push;
        logic       rx_pop;
        logic       tx_push;
        logic       tx_pop;
        logic       rx_flush;
        logic       tx_flush;
        logic [1:0] inc_err;
        logic       inc_ovf;
        logic       inc_frm;
        logic       inc_par;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic rx_empty;
        logic rx_full;
        logic tx_empty;
        logic tx_full;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: design/bsfp_ram.sv
// ----------------------------------------------------------------------------
// bsfp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/bsfp_datapath.sv
// ----------------------------------------------------------------------------
// bsfp_datapath
// Receive and transmit byte FIFOs with pointers and fill counts, plus the
// wrapping statistics counters.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfp_datapath
    import bsfp_pkg::*;
#(
    parameter int FIFO_DEPTH   = 128,
    parameter int COUNTER_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    input  wire logic [7:0]  i_data_in,
    output t_dp_stat         o_stat,
    output logic [7:0]       o_data_out,
    output logic [7:0]       o_rx_fill,
    output logic [7:0]       o_tx_fill,
    output logic [15:0]      o_errors_total,
    output logic [15:0]      o_overflows_total,
    output logic [15:0]      o_framing_total,
    output logic [15:0]      o_parity_total,
    output logic [15:0]      o_received_total,
    output logic [15:0]      o_queued_total
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(FIFO_DEPTH);

    logic [PW-1:0] r_rx_rd, r_rx_wr, r_tx_rd, r_tx_wr;
    logic [PW-1:0] n_rx_rd, n_rx_wr, n_tx_rd, n_tx_wr;
    logic [CW-1:0] r_rx_cnt, r_tx_cnt, n_rx_cnt, n_tx_cnt;
    logic [COUNTER_BITS-1:0] r_err, r_ovf, r_frm, r_par, r_rcv, r_que;
    logic          r_pop_rx, r_pop_tx;
    logic [7:0]    rx_rdata, tx_rdata;

    // fifo status
    assign o_stat.rx_empty = (r_rx_cnt == '0);
    assign o_stat.rx_full  = (r_rx_cnt == CNT_FULL);
    assign o_stat.tx_empty = (r_tx_cnt == '0);
    assign o_stat.tx_full  = (r_tx_cnt == CNT_FULL);

    // byte stores
    bsfp_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.rx_push),
        .i_waddr (r_rx_wr),
        .i_wdata (i_data_in),
        .i_re    (i_cmd.rx_pop),
        .i_raddr (r_rx_rd),
        .o_rdata (rx_rdata)
    );

    bsfp_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.tx_push),
        .i_waddr (r_tx_wr),
        .i_wdata (i_data_in),
        .i_re    (i_cmd.tx_pop),
        .i_raddr (r_tx_rd),
        .o_rdata (tx_rdata)
    );

    // receive pointer and count update
    always_comb begin
        n_rx_rd  = r_rx_rd;
        n_rx_wr  = r_rx_wr;
        n_rx_cnt = r_rx_cnt;
        if (i_cmd.rx_flush) begin
            n_rx_rd  = '0;
            n_rx_wr  = '0;
            n_rx_cnt = '0;
        end else if (i_cmd.rx_push) begin
            n_rx_wr  = (r_rx_wr == PTR_LAST) ? '0 : r_rx_wr + PW'(1);
            n_rx_cnt = r_rx_cnt + CW'(1);
        end else if (i_cmd.rx_pop) begin
            n_rx_rd  = (r_rx_rd == PTR_LAST) ? '0 : r_rx_rd + PW'(1);
            n_rx_cnt = r_rx_cnt - CW'(1);
        end
    end

    // transmit pointer and count update
    always_comb begin
        n_tx_rd  = r_tx_rd;
        n_tx_wr  = r_tx_wr;
        n_tx_cnt = r_tx_cnt;
        if (i_cmd.tx_flush) begin
            n_tx_rd  = '0;
            n_tx_wr  = '0;
            n_tx_cnt = '0;
        end else if (i_cmd.tx_push) begin
            n_tx_wr  = (r_tx_wr == PTR_LAST) ? '0 : r_tx_wr + PW'(1);
            n_tx_cnt = r_tx_cnt + CW'(1);
        end else if (i_cmd.tx_pop) begin
            n_tx_rd  = (r_tx_rd == PTR_LAST) ? '0 : r_tx_rd + PW'(1);
            n_tx_cnt = r_tx_cnt - CW'(1);
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_rd  <= '0;
            r_rx_wr  <= '0;
            r_rx_cnt <= '0;
            r_tx_rd  <= '0;
            r_tx_wr  <= '0;
            r_tx_cnt <= '0;
            r_err    <= '0;
            r_ovf    <= '0;
            r_frm    <= '0;
            r_par    <= '0;
            r_rcv    <= '0;
            r_que    <= '0;
            r_pop_rx <= 1'b0;
            r_pop_tx <= 1'b0;
        end else begin
            r_rx_rd  <= n_rx_rd;
            r_rx_wr  <= n_rx_wr;
            r_rx_cnt <= n_rx_cnt;
            r_tx_rd  <= n_tx_rd;
            r_tx_wr  <= n_tx_wr;
            r_tx_cnt <= n_tx_cnt;
            r_err    <= r_err + COUNTER_BITS'(i_cmd.inc_err);
            r_ovf    <= r_ovf + COUNTER_BITS'(i_cmd.inc_ovf);
            r_frm    <= r_frm + COUNTER_BITS'(i_cmd.inc_frm);
            r_par    <= r_par + COUNTER_BITS'(i_cmd.inc_par);
            r_rcv    <= r_rcv + COUNTER_BITS'(i_cmd.rx_push);
            r_que    <= r_que + COUNTER_BITS'(i_cmd.tx_push);
            // remember which store feeds the output byte
            if (i_cmd.take) begin
                r_pop_rx <= i_cmd.rx_pop;
                r_pop_tx <= i_cmd.tx_pop;
            end
        end
    end

    // result fields
    assign o_data_out        = r_pop_rx ? rx_rdata : (r_pop_tx ? tx_rdata : 8'd0);
    assign o_rx_fill         = 8'(r_rx_cnt);
    assign o_tx_fill         = 8'(r_tx_cnt);
    assign o_errors_total    = 16'(r_err);
    assign o_overflows_total = 16'(r_ovf);
    assign o_framing_total   = 16'(r_frm);
    assign o_parity_total    = 16'(r_par);
    assign o_received_total  = 16'(r_rcv);
    assign o_queued_total    = 16'(r_que);

    // checks
    a_rx_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rx_cnt <= CNT_FULL) && (r_tx_cnt <= CNT_FULL))
        else $error("fifo count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.rx_push && o_stat.rx_full) && !(i_cmd.tx_push && o_stat.tx_full))
        else $error("push into full fifo");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rx_pop && !i_cmd.rx_flush |=> r_rx_cnt == $past(r_rx_cnt) - CW'(1))
        else $error("rx pop did not lower count");

endmodule

`default_nettype wire

FILE: design/bsfp_ctrl.sv
// ----------------------------------------------------------------------------
// bsfp_ctrl
// Handshake controller: decodes each accepted item into datapath commands,
// picks the result code and holds the result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfp_ctrl
    import bsfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [2:0] i_operation,
    input  wire logic       i_framing_flag,
    input  wire logic       i_overrun_flag,
    input  wire logic       i_parity_flag,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_result_code,
    output logic            o_data_valid,
    input  wire t_dp_stat   i_stat,
    output t_dp_cmd         o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } t_state;

    t_state     r_state;
    logic [1:0] r_code, n_code;
    logic       r_valid, n_valid;
    logic       accept, any_flag, is_line;

    // accept when no result waits or the waiting one leaves now
    assign o_in_ready  = (r_state == S_IDLE) || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign any_flag    = i_framing_flag || i_overrun_flag || i_parity_flag;
    assign is_line     = accept && (i_operation == OP_LINE_RX);

    // datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.take     = accept;
        o_cmd.rx_push  = is_line && !any_flag && !i_stat.rx_full;
        o_cmd.rx_pop   = accept && (i_operation == OP_CPU_READ) && !i_stat.rx_empty;
        o_cmd.tx_push  = accept && (i_operation == OP_CPU_WRITE) && !i_stat.tx_full;
        o_cmd.tx_pop   = accept && (i_operation == OP_TX_READY) && !i_stat.tx_empty;
        o_cmd.rx_flush = accept && (i_operation == OP_FLUSH_RX);
        o_cmd.tx_flush = accept && (i_operation == OP_FLUSH_TX);
        o_cmd.inc_frm  = is_line && i_framing_flag;
        o_cmd.inc_par  = is_line && i_parity_flag;
        o_cmd.inc_ovf  = is_line && (i_overrun_flag || (!any_flag && i_stat.rx_full));
        if (is_line) begin
            if (any_flag) begin
                o_cmd.inc_err = 2'(i_framing_flag) + 2'(i_overrun_flag)
                              + 2'(i_parity_flag);
            end else begin
                o_cmd.inc_err = 2'(i_stat.rx_full);
            end
        end
    end

    // result code and popped flag
    always_comb begin
        n_code  = RC_OK;
        n_valid = 1'b0;
        case (i_operation)
            OP_LINE_RX: begin
                if (any_flag) begin
                    n_code = RC_LINE_ERR;
                end else if (i_stat.rx_full) begin
                    n_code = RC_FULL;
                end
            end
            OP_CPU_READ: begin
                n_valid = !i_stat.rx_empty;
                n_code  = i_stat.rx_empty ? RC_EMPTY : RC_OK;
            end
            OP_CPU_WRITE: begin
                n_code = i_stat.tx_full ? RC_FULL : RC_OK;
            end
            OP_TX_READY: begin
                n_valid = !i_stat.tx_empty;
                n_code  = i_stat.tx_empty ? RC_EMPTY : RC_OK;
            end
            default: begin
                n_code = RC_OK;
            end
        endcase
    end

    // state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= RC_OK;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_HOLD;
                        r_code  <= n_code;
                        r_valid <= n_valid;
                    end
                end
                S_HOLD: begin
                    if (accept) begin
                        r_code  <= n_code;
                        r_valid <= n_valid;
                    end else if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = (r_state == S_HOLD);
    assign o_result_code = r_code;
    assign o_data_valid  = r_valid;

    // checks
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted item left no result");

    a_popped_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_data_valid |-> o_result_code == RC_OK)
        else $error("popped byte with non-ok code");

    a_one_fifo_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.rx_push, o_cmd.rx_pop, o_cmd.tx_push, o_cmd.tx_pop,
                    o_cmd.rx_flush, o_cmd.tx_flush}) <= 1)
        else $error("more than one fifo operation per item");

endmodule

`default_nettype wire

FILE: design/buffered_serial_fifo_pair_unit.sv
// ----------------------------------------------------------------------------
// buffered_serial_fifo_pair_unit
// Buffered front of a serial port: receive and transmit byte FIFOs with
// line-error filtering and wrapping statistics counters.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | i_in_valid/o_in_ready  | operation, data_in, three line flags
//  out     | o_out_valid/i_out_ready| result_code, data_out, fills, counters
//
//  Each item is decoded and applied to the FIFO state on the accepting edge;
//  its result is registered on that edge and offered from the next cycle,
//  one item per cycle sustained while i_out_ready stays high.
//  The popped byte comes from the registered read port of the FIFO store.
//  A new item is taken while a result waits only in the cycle that result is taken.
//  Synchronous active-low reset empties both FIFOs and zeroes all counters.
// ----------------------------------------------------------------------------
`default_nettype none

module buffered_serial_fifo_pair_unit
    import bsfp_pkg::*;
#(
    parameter int FIFO_DEPTH   = 128,
    parameter int COUNTER_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_operation,
    input  wire logic [7:0]  i_data_in,
    input  wire logic        i_framing_flag,
    input  wire logic        i_overrun_flag,
    input  wire logic        i_parity_flag,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_result_code,
    output logic [7:0]       o_data_out,
    output logic             o_data_valid,
    output logic [7:0]       o_rx_fill,
    output logic [7:0]       o_tx_fill,
    output logic [15:0]      o_errors_total,
    output logic [15:0]      o_overflows_total,
    output logic [15:0]      o_framing_total,
    output logic [15:0]      o_parity_total,
    output logic [15:0]      o_received_total,
    output logic [15:0]      o_queued_total
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // controller
    bsfp_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_framing_flag (i_framing_flag),
        .i_overrun_flag (i_overrun_flag),
        .i_parity_flag  (i_parity_flag),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_code  (o_result_code),
        .o_data_valid   (o_data_valid),
        .i_stat         (dp_stat),
        .o_cmd          (dp_cmd)
    );

    // datapath
    bsfp_datapath #(
        .FIFO_DEPTH   (FIFO_DEPTH),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .i_data_in         (i_data_in),
        .o_stat            (dp_stat),
        .o_data_out        (o_data_out),
        .o_rx_fill         (o_rx_fill),
        .o_tx_fill         (o_tx_fill),
        .o_errors_total    (o_errors_total),
        .o_overflows_total (o_overflows_total),
        .o_framing_total   (o_framing_total),
        .o_parity_total    (o_parity_total),
        .o_received_total  (o_received_total),
        .o_queued_total    (o_queued_total)
    );

endmodule

`default_nettype wire

FILE: test/tb_buffered_serial_fifo_pair_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buffered_serial_fifo_pair_unit
// Self-checking bench for the buffered serial FIFO pair. A behavioral copy of
// both byte FIFOs and the six statistics counters predicts the response to
// every accepted item; responses are checked field by field, in order, under
// random idling on the request and response sides.
// ----------------------------------------------------------------------------

module tb_buffered_serial_fifo_pair_unit;
    import bsfp_pkg::*;

    localparam int FIFO_DEPTH   = 128;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    // codes the block accepts and ignores
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    // flag bundle order {framing, overrun, parity}
    localparam logic [2:0] FLAGS_NONE    = 3'b000;
    localparam logic [2:0] FLAGS_FRAMING = 3'b100;
    localparam logic [2:0] FLAGS_OVERRUN = 3'b010;
    localparam logic [2:0] FLAGS_PARITY  = 3'b001;
    localparam logic [2:0] FLAGS_ALL     = 3'b111;

    typedef struct packed {
        logic [1:0]  result_code;
        logic [7:0]  data_out;
        logic        data_valid;
        logic [7:0]  rx_fill;
        logic [7:0]  tx_fill;
        logic [15:0] errors_total;
        logic [15:0] overflows_total;
        logic [15:0] framing_total;
        logic [15:0] parity_total;
        logic [15:0] received_total;
        logic [15:0] queued_total;
    } t_port_response;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [2:0]  i_operation = OP_LINE_RX;
    logic [7:0]  i_data_in = 8'h00;
    logic        i_framing_flag = 1'b0;
    logic        i_overrun_flag = 1'b0;
    logic        i_parity_flag = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_result_code;
    logic [7:0]  o_data_out;
    logic        o_data_valid;
    logic [7:0]  o_rx_fill;
    logic [7:0]  o_tx_fill;
    logic [15:0] o_errors_total;
    logic [15:0] o_overflows_total;
    logic [15:0] o_framing_total;
    logic [15:0] o_parity_total;
    logic [15:0] o_received_total;
    logic [15:0] o_queued_total;

    buffered_serial_fifo_pair_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_data_in        (i_data_in),
        .i_framing_flag   (i_framing_flag),
        .i_overrun_flag   (i_overrun_flag),
        .i_parity_flag    (i_parity_flag),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_code    (o_result_code),
        .o_data_out       (o_data_out),
        .o_data_valid     (o_data_valid),
        .o_rx_fill        (o_rx_fill),
        .o_tx_fill        (o_tx_fill),
        .o_errors_total   (o_errors_total),
        .o_overflows_total(o_overflows_total),
        .o_framing_total  (o_framing_total),
        .o_parity_total   (o_parity_total),
        .o_received_total (o_received_total),
        .o_queued_total   (o_queued_total)
    );

    // shadow copy of both fifos and the statistics counters
    logic [7:0]  rx_bytes [FIFO_DEPTH];
    logic [7:0]  tx_bytes [FIFO_DEPTH];
    logic [6:0]  rx_head = '0, rx_tail = '0, tx_head = '0, tx_tail = '0;
    logic [7:0]  rx_level = '0, tx_level = '0;
    logic [15:0] errors_seen = '0, overflows_seen = '0, framing_seen = '0;
    logic [15:0] parity_seen = '0, received_seen = '0, queued_seen = '0;

    t_port_response pending_responses [$];
    t_port_response oldest_response;
    int             mismatch_count = 0;
    int             cycle_count = 0;
    int unsigned    send_idle_pct = 0;
    int unsigned    recv_idle_pct = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // update the shadow state for one item and queue the response it causes
    task automatic apply_port_op(input logic [2:0] op, input logic [7:0] data,
                                 input logic [2:0] flags);
        t_port_response rsp;
        rsp = '0;
        rsp.result_code = RC_OK;
        case (op)
            OP_LINE_RX: begin
                if (flags != FLAGS_NONE) begin
                    if (flags[2]) begin framing_seen++; errors_seen++; end
                    if (flags[1]) begin overflows_seen++; errors_seen++; end
                    if (flags[0]) begin parity_seen++; errors_seen++; end
                    rsp.result_code = RC_LINE_ERR;
                end else if (rx_level < FIFO_DEPTH) begin
                    rx_bytes[rx_tail] = data;
                    rx_tail++;
                    rx_level++;
                    received_seen++;
                end else begin
                    overflows_seen++;
                    errors_seen++;
                    rsp.result_code = RC_FULL;
                end
            end
            OP_CPU_READ: begin
                if (rx_level != 0) begin
                    rsp.data_out   = rx_bytes[rx_head];
                    rsp.data_valid = 1'b1;
                    rx_head++;
                    rx_level--;
                end else begin
                    rsp.result_code = RC_EMPTY;
                end
            end
            OP_CPU_WRITE: begin
                if (tx_level < FIFO_DEPTH) begin
                    tx_bytes[tx_tail] = data;
                    tx_tail++;
                    tx_level++;
                    queued_seen++;
                end else begin
                    rsp.result_code = RC_FULL;
                end
            end
            OP_TX_READY: begin
                if (tx_level != 0) begin
                    rsp.data_out   = tx_bytes[tx_head];
                    rsp.data_valid = 1'b1;
                    tx_head++;
                    tx_level--;
                end else begin
                    rsp.result_code = RC_EMPTY;
                end
            end
            OP_FLUSH_RX: begin
                rx_head  = '0;
                rx_tail  = '0;
                rx_level = '0;
            end
            OP_FLUSH_TX: begin
                tx_head  = '0;
                tx_tail  = '0;
                tx_level = '0;
            end
            default: ;
        endcase
        rsp.rx_fill         = rx_level;
        rsp.tx_fill         = tx_level;
        rsp.errors_total    = errors_seen;
        rsp.overflows_total = overflows_seen;
        rsp.framing_total   = framing_seen;
        rsp.parity_total    = parity_seen;
        rsp.received_total  = received_seen;
        rsp.queued_total    = queued_seen;
        pending_responses.push_back(rsp);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // response side: check accepted responses, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_responses.size() == 0) begin
                $error("response with no item pending");
                mismatch_count++;
            end else begin
                oldest_response = pending_responses.pop_front();
                check_field("result_code", 32'(oldest_response.result_code),
                            32'(o_result_code));
                check_field("data_out", 32'(oldest_response.data_out),
                            32'(o_data_out));
                check_field("data_valid", 32'(oldest_response.data_valid),
                            32'(o_data_valid));
                check_field("rx_fill", 32'(oldest_response.rx_fill),
                            32'(o_rx_fill));
                check_field("tx_fill", 32'(oldest_response.tx_fill),
                            32'(o_tx_fill));
                check_field("errors_total", 32'(oldest_response.errors_total),
                            32'(o_errors_total));
                check_field("overflows_total", 32'(oldest_response.overflows_total),
                            32'(o_overflows_total));
                check_field("framing_total", 32'(oldest_response.framing_total),
                            32'(o_framing_total));
                check_field("parity_total", 32'(oldest_response.parity_total),
                            32'(o_parity_total));
                check_field("received_total", 32'(oldest_response.received_total),
                            32'(o_received_total));
                check_field("queued_total", 32'(oldest_response.queued_total),
                            32'(o_queued_total));
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // present one item, hold it until taken, then predict its response
    task automatic send_item(input logic [2:0] op, input logic [7:0] data,
                             input logic [2:0] flags);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_data_in      <= data;
        i_framing_flag <= flags[2];
        i_overrun_flag <= flags[1];
        i_parity_flag  <= flags[0];
        do @(posedge i_clk); while (!o_in_ready);
        apply_port_op(op, data, flags);
    endtask

    // hold off new items until every response is back
    task automatic wait_all_responses();
        i_in_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [2:0] core_op(input int unsigned idx);
        case (idx)
            0: return OP_LINE_RX;
            1: return OP_CPU_READ;
            2: return OP_CPU_WRITE;
            default: return OP_TX_READY;
        endcase
    endfunction

    function automatic logic [2:0] random_flags(input int unsigned pct);
        return {$urandom_range(99) < pct, $urandom_range(99) < pct,
                $urandom_range(99) < pct};
    endfunction

    // empty fifos, each line flag alone and together, byte extremes, flushes
    task automatic test_directed();
        send_item(OP_TX_READY, 8'hFF, FLAGS_ALL);
        send_item(OP_CPU_READ, 8'h00, FLAGS_NONE);
        send_item(OP_LINE_RX, 8'hFF, FLAGS_FRAMING);
        send_item(OP_LINE_RX, 8'hFF, FLAGS_OVERRUN);
        send_item(OP_LINE_RX, 8'hFF, FLAGS_PARITY);
        send_item(OP_LINE_RX, 8'h00, FLAGS_ALL);
        send_item(OP_LINE_RX, 8'h00, FLAGS_NONE);
        send_item(OP_LINE_RX, 8'hFF, FLAGS_NONE);
        send_item(OP_LINE_RX, 8'hA5, FLAGS_NONE);
        repeat (3) send_item(OP_CPU_READ, 8'h00, FLAGS_NONE);
        send_item(OP_CPU_WRITE, 8'hFF, FLAGS_ALL);
        send_item(OP_CPU_WRITE, 8'h00, FLAGS_NONE);
        repeat (2) send_item(OP_TX_READY, 8'h00, FLAGS_NONE);
        send_item(OP_LINE_RX, 8'h5A, FLAGS_NONE);
        send_item(OP_CPU_WRITE, 8'h3C, FLAGS_NONE);
        send_item(OP_FLUSH_RX, 8'hFF, FLAGS_ALL);
        send_item(OP_FLUSH_TX, 8'h00, FLAGS_NONE);
        send_item(OP_CPU_READ, 8'h00, FLAGS_NONE);
        send_item(OP_TX_READY, 8'h00, FLAGS_NONE);
        send_item(OP_SPARE_A, 8'hFF, FLAGS_ALL);
        send_item(OP_SPARE_B, 8'hFF, FLAGS_ALL);
    endtask

    // fill both fifos past full, then drain both past empty
    task automatic test_fifo_limits();
        repeat (FIFO_DEPTH + 3) begin
            send_item(OP_LINE_RX, 8'($urandom_range(255)), FLAGS_NONE);
            send_item(OP_CPU_WRITE, 8'($urandom_range(255)), random_flags(20));
        end
        repeat (FIFO_DEPTH + 2) begin
            send_item(OP_CPU_READ, 8'($urandom_range(255)), random_flags(20));
            send_item(OP_TX_READY, 8'($urandom_range(255)), random_flags(20));
        end
    endtask

    // bursts that lean toward filling or draining one fifo, with some noise
    task automatic test_mixed_traffic(input int n_items);
        int          sent;
        int unsigned lean;
        int unsigned pick;
        logic [2:0]  op;
        sent = 0;
        while (sent < n_items) begin
            lean = $urandom_range(3);
            repeat ($urandom_range(40, 1)) begin
                pick = $urandom_range(99);
                if (pick < 3)
                    op = $urandom_range(1) ? OP_FLUSH_RX : OP_FLUSH_TX;
                else if (pick < 5)
                    op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
                else if (pick < 70)
                    op = core_op(lean);
                else
                    op = core_op($urandom_range(3));
                send_item(op, 8'($urandom_range(255)), random_flags(12));
                if (op != OP_SPARE_A && op != OP_SPARE_B)
                    sent++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // slow sender, very slow receiver
        send_idle_pct = 19;
        recv_idle_pct = 84;
        test_directed();
        test_fifo_limits();
        wait_all_responses();

        // very slow sender, slow receiver
        send_idle_pct = 84;
        recv_idle_pct = 19;
        test_mixed_traffic(150);
        wait_all_responses();

        // full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_mixed_traffic(150);
        wait_all_responses();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_responses.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
